### rtl/esse_pkg.sv
package esse_pkg;

  localparam int ENT_W   = 10;
  localparam int CNT_W   = 11;
  localparam int TYPE_W  = 3;
  localparam int NTYPES  = 8;
  localparam int DATA_W  = 32;
  localparam int SLOT_AW = TYPE_W + ENT_W;

  localparam logic [2:0] F_ENT_ADD  = 3'd0;
  localparam logic [2:0] F_ENT_REM  = 3'd1;
  localparam logic [2:0] F_COMP_ADD = 3'd2;
  localparam logic [2:0] F_COMP_REM = 3'd3;
  localparam logic [2:0] F_QUERY    = 3'd4;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_UNREG   = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_POP,
    S_SCAN,
    S_SPARSE,
    S_OWNER,
    S_CHECK,
    S_DROP_RD,
    S_DROP_WR,
    S_ADV,
    S_QREAD,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic    ld_in;
    logic    pop;
    logic    push;
    logic    fresh_inc;
    logic    k_from_t;
    logic    k_clr;
    logic    k_inc;
    logic    rd_sparse;
    logic    rd_owner_s;
    logic    rd_last;
    logic    rd_pay_s;
    logic    wr_pay_s;
    logic    append;
    logic    drop_wr;
    logic    set_st;
    status_t st;
    logic    id_fresh;
    logic    id_stack;
    logic    data_pay;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       free_nz;
    logic       ent_issued;
    logic       fresh_avail;
    logic       free_full;
    logic       t_usable;
    logic       k_usable;
    logic       k_last;
    logic       member;
    logic       count_full;
    logic       out_free;
  } stat_t;

endpackage

### rtl/esse_ctrl.sv
module esse_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  esse_pkg::stat_t st,
  output esse_pkg::cmd_t  cmd
);

  esse_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= esse_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      esse_pkg::S_IDLE:   if (in_valid) state_next = esse_pkg::S_DECODE;
      esse_pkg::S_DECODE: begin
        state_next = esse_pkg::S_FINISH;
        priority case (st.func)
          esse_pkg::F_ENT_ADD: if (st.free_nz) state_next = esse_pkg::S_POP;
          esse_pkg::F_ENT_REM:
            if (st.ent_issued && !st.free_full) state_next = esse_pkg::S_SCAN;
          esse_pkg::F_COMP_ADD, esse_pkg::F_COMP_REM:
            if (st.ent_issued && st.t_usable) state_next = esse_pkg::S_SPARSE;
          esse_pkg::F_QUERY: if (st.t_usable) state_next = esse_pkg::S_SPARSE;
          default: state_next = esse_pkg::S_FINISH;
        endcase
      end
      esse_pkg::S_POP:    state_next = esse_pkg::S_FINISH;
      esse_pkg::S_SCAN:
        state_next = st.k_usable ? esse_pkg::S_SPARSE : esse_pkg::S_ADV;
      esse_pkg::S_ADV:
        state_next = st.k_last ? esse_pkg::S_FINISH : esse_pkg::S_SCAN;
      esse_pkg::S_SPARSE: state_next = esse_pkg::S_OWNER;
      esse_pkg::S_OWNER:  state_next = esse_pkg::S_CHECK;
      esse_pkg::S_CHECK: begin
        state_next = esse_pkg::S_FINISH;
        priority case (st.func)
          esse_pkg::F_ENT_REM:
            state_next = st.member ? esse_pkg::S_DROP_RD : esse_pkg::S_ADV;
          esse_pkg::F_COMP_REM: if (st.member) state_next = esse_pkg::S_DROP_RD;
          esse_pkg::F_QUERY:    if (st.member) state_next = esse_pkg::S_QREAD;
          default:              state_next = esse_pkg::S_FINISH;
        endcase
      end
      esse_pkg::S_DROP_RD: state_next = esse_pkg::S_DROP_WR;
      esse_pkg::S_DROP_WR:
        state_next = (st.func == esse_pkg::F_ENT_REM) ? esse_pkg::S_ADV
                                                      : esse_pkg::S_FINISH;
      esse_pkg::S_QREAD:  state_next = esse_pkg::S_FINISH;
      esse_pkg::S_FINISH: if (st.out_free) state_next = esse_pkg::S_IDLE;
      default:            state_next = esse_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.st = esse_pkg::ST_INVALID;
    in_ready = 1'b0;
    unique case (state)
      esse_pkg::S_IDLE: begin
        in_ready  = 1'b1;
        cmd.ld_in = in_valid;
      end
      esse_pkg::S_DECODE: begin
        cmd.set_st = 1'b1;
        cmd.st = esse_pkg::ST_INVALID;
        priority case (st.func)
          esse_pkg::F_ENT_ADD: begin
            if (st.free_nz) begin
              cmd.pop = 1'b1;
            end else if (st.fresh_avail) begin
              cmd.fresh_inc = 1'b1;
              cmd.id_fresh  = 1'b1;
              cmd.st = esse_pkg::ST_OK;
            end else begin
              cmd.st = esse_pkg::ST_FULL;
            end
          end
          esse_pkg::F_ENT_REM: begin
            if (!st.ent_issued) begin
              cmd.st = esse_pkg::ST_INVALID;
            end else if (st.free_full) begin
              cmd.st = esse_pkg::ST_FULL;
            end else begin
              cmd.push  = 1'b1;
              cmd.k_clr = 1'b1;
              cmd.st = esse_pkg::ST_OK;
            end
          end
          esse_pkg::F_COMP_ADD, esse_pkg::F_COMP_REM: begin
            if (!st.ent_issued) begin
              cmd.st = esse_pkg::ST_INVALID;
            end else if (!st.t_usable) begin
              cmd.st = esse_pkg::ST_UNREG;
            end else begin
              cmd.k_from_t = 1'b1;
            end
          end
          esse_pkg::F_QUERY: begin
            if (!st.t_usable) begin
              cmd.st = esse_pkg::ST_UNREG;
            end else begin
              cmd.k_from_t = 1'b1;
            end
          end
          default: cmd.st = esse_pkg::ST_INVALID;
        endcase
      end
      esse_pkg::S_POP: begin
        cmd.id_stack = 1'b1;
        cmd.set_st = 1'b1;
        cmd.st = esse_pkg::ST_OK;
      end
      esse_pkg::S_ADV:    cmd.k_inc = !st.k_last;
      esse_pkg::S_SPARSE: cmd.rd_sparse = 1'b1;
      esse_pkg::S_OWNER:  cmd.rd_owner_s = 1'b1;
      esse_pkg::S_CHECK: begin
        priority case (st.func)
          esse_pkg::F_COMP_ADD: begin
            cmd.set_st = 1'b1;
            if (st.member) begin
              cmd.wr_pay_s = 1'b1;
              cmd.st = esse_pkg::ST_OK;
            end else if (st.count_full) begin
              cmd.st = esse_pkg::ST_FULL;
            end else begin
              cmd.append = 1'b1;
              cmd.st = esse_pkg::ST_OK;
            end
          end
          esse_pkg::F_COMP_REM: begin
            cmd.set_st = !st.member;
            cmd.st = esse_pkg::ST_INVALID;
          end
          esse_pkg::F_QUERY: begin
            cmd.rd_pay_s = st.member;
            cmd.set_st = !st.member;
            cmd.st = esse_pkg::ST_INVALID;
          end
          default: cmd.set_st = 1'b0;
        endcase
      end
      esse_pkg::S_DROP_RD: cmd.rd_last = 1'b1;
      esse_pkg::S_DROP_WR: begin
        cmd.drop_wr = 1'b1;
        cmd.set_st = (st.func != esse_pkg::F_ENT_REM);
        cmd.st = esse_pkg::ST_OK;
      end
      esse_pkg::S_QREAD: begin
        cmd.data_pay = 1'b1;
        cmd.set_st = 1'b1;
        cmd.st = esse_pkg::ST_OK;
      end
      esse_pkg::S_FINISH: cmd.out_load = st.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

### rtl/esse_dpath.sv
module esse_dpath (
  input  logic            clk,
  input  logic            rst,
  input  logic [47:0]     in_data,
  input  logic            cfg_we,
  input  logic [7:0]      cfg_data,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [47:0]     out_data,
  input  esse_pkg::cmd_t  cmd,
  output esse_pkg::stat_t st
);

  localparam int EW = esse_pkg::ENT_W;
  localparam int CW = esse_pkg::CNT_W;
  localparam int TW = esse_pkg::TYPE_W;
  localparam int DW = esse_pkg::DATA_W;
  localparam int AW = esse_pkg::SLOT_AW;

  logic [2:0]    func;
  logic [EW-1:0] ent;
  logic [TW-1:0] typ;
  logic [DW-1:0] din;

  logic [7:0]    mask;
  logic [CW-1:0] fresh;
  logic [CW-1:0] free_cnt;
  logic [CW-1:0] cnt [esse_pkg::NTYPES];
  logic [TW-1:0] k;
  logic [EW-1:0] slot;

  esse_pkg::status_t status;
  logic [EW-1:0] id_res;
  logic [DW-1:0] data_res;

  logic [EW-1:0] stack_mem [2**EW];
  logic [EW-1:0] sparse_mem [2**AW];
  logic [EW-1:0] owner_mem [2**AW];
  logic [DW-1:0] pay_mem [2**AW];
  logic [EW-1:0] stack_q, sparse_q, owner_q;
  logic [DW-1:0] pay_q;

  logic [CW-1:0] cnt_k;
  logic [EW-1:0] last;
  logic [CW-1:0] free_dec;

  assign cnt_k    = cnt[k];
  assign last     = EW'(cnt_k - CW'(1));
  assign free_dec = free_cnt - CW'(1);

  assign st.func        = func;
  assign st.free_nz     = (free_cnt != '0);
  assign st.ent_issued  = ({1'b0, ent} < fresh);
  assign st.fresh_avail = !fresh[CW-1];
  assign st.free_full   = free_cnt[CW-1];
  assign st.t_usable    = mask[typ];
  assign st.k_usable    = mask[k];
  assign st.k_last      = (k == TW'(esse_pkg::NTYPES - 1));
  assign st.member      = ({1'b0, slot} < cnt_k) && (owner_q == ent);
  assign st.count_full  = cnt_k[CW-1];
  assign st.out_free    = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      func <= in_data[2:0];
      ent  <= in_data[12:3];
      typ  <= in_data[15:13];
      din  <= in_data[47:16];
    end
    if (cmd.k_from_t) begin
      k <= typ;
    end else if (cmd.k_clr) begin
      k <= '0;
    end else if (cmd.k_inc) begin
      k <= k + TW'(1);
    end
    if (cmd.rd_owner_s) slot <= sparse_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask     <= '0;
      fresh    <= '0;
      free_cnt <= '0;
      for (int i = 0; i < esse_pkg::NTYPES; i++) cnt[i] <= '0;
    end else begin
      if (cfg_we) begin
        mask <= cfg_data;
        for (int i = 0; i < esse_pkg::NTYPES; i++) begin
          if (!cfg_data[i]) cnt[i] <= '0;
        end
      end
      if (cmd.fresh_inc) fresh <= fresh + CW'(1);
      if (cmd.pop) begin
        free_cnt <= free_dec;
      end else if (cmd.push) begin
        free_cnt <= free_cnt + CW'(1);
      end
      if (cmd.append) begin
        cnt[k] <= cnt_k + CW'(1);
      end else if (cmd.drop_wr) begin
        cnt[k] <= cnt_k - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) stack_mem[free_cnt[EW-1:0]] <= ent;
    if (cmd.pop) stack_q <= stack_mem[free_dec[EW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.append) begin
      sparse_mem[{k, ent}] <= cnt_k[EW-1:0];
    end else if (cmd.drop_wr) begin
      sparse_mem[{k, owner_q}] <= slot;
    end
    if (cmd.rd_sparse) sparse_q <= sparse_mem[{k, ent}];
  end

  always_ff @(posedge clk) begin
    if (cmd.append) begin
      owner_mem[{k, cnt_k[EW-1:0]}] <= ent;
    end else if (cmd.drop_wr) begin
      owner_mem[{k, slot}] <= owner_q;
    end
    if (cmd.rd_owner_s) begin
      owner_q <= owner_mem[{k, sparse_q}];
    end else if (cmd.rd_last) begin
      owner_q <= owner_mem[{k, last}];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.append) begin
      pay_mem[{k, cnt_k[EW-1:0]}] <= din;
    end else if (cmd.wr_pay_s) begin
      pay_mem[{k, slot}] <= din;
    end else if (cmd.drop_wr) begin
      pay_mem[{k, slot}] <= pay_q;
    end
    if (cmd.rd_last) begin
      pay_q <= pay_mem[{k, last}];
    end else if (cmd.rd_pay_s) begin
      pay_q <= pay_mem[{k, slot}];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      status   <= esse_pkg::ST_INVALID;
      id_res   <= '0;
      data_res <= '0;
    end else begin
      if (cmd.set_st) status <= cmd.st;
      if (cmd.id_fresh) begin
        id_res <= fresh[EW-1:0];
      end else if (cmd.id_stack) begin
        id_res <= stack_q;
      end
      if (cmd.data_pay) data_res <= pay_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) out_data <= {4'b0, data_res, id_res, status};
  end

endmodule

### rtl/entity_sparse_set_engine.sv
// Entity id allocator with eight sparse-set component stores (1024 entities,
// 32-bit component data). One operation per input beat, one result beat per
// operation. Component operations and queries walk a chain of registered memory
// reads (sparse slot, owner, then payload for a query or a drop); entity add reads
// the free stack when it holds ids, and operations rejected at decode skip the
// reads. Entity remove repeats the lookup for every enabled type, skips disabled
// types and drops the entity from each set that holds it. The result waits while
// the output register stays full. The next beat is taken once the result is in
// the output register. Config writes are taken at any time but must only be
// issued while the block is idle.
module entity_sparse_set_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // func[2:0], entity[12:3], comp_type[15:13], data_in[47:16]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // status[1:0], entity_out[11:2], data_out[43:12], zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data   // type_enable_mask
);

  esse_pkg::cmd_t  cmd;
  esse_pkg::stat_t st;

  assign cfg_ready = 1'b1;

  esse_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  esse_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (s_tdata),
    .cfg_we    (cfg_valid),
    .cfg_data  (cfg_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

### test/tb_entity_sparse_set_engine.sv
module tb_entity_sparse_set_engine;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    esse_pkg::status_t           status;
    logic [esse_pkg::ENT_W-1:0]  ent;
    logic [esse_pkg::DATA_W-1:0] data;
  } result_t;

  // tracks outcomes of the sparse-set engine and compares result beats
  class entity_store_board;
    logic [7:0]                  enable_mask;
    int unsigned                 fresh_cnt;
    int unsigned                 free_cnt;
    logic [esse_pkg::ENT_W-1:0]  free_ids[1024];
    int unsigned                 slot_of[esse_pkg::NTYPES][1024];
    int unsigned                 owner_of[esse_pkg::NTYPES][1024];
    logic [esse_pkg::DATA_W-1:0] payload[esse_pkg::NTYPES][1024];
    int unsigned                 members[esse_pkg::NTYPES];
    result_t                     pending[$];
    int                          errors;

    function new();
      enable_mask = 0;
      fresh_cnt = 0;
      free_cnt = 0;
      errors = 0;
      foreach (members[t]) members[t] = 0;
      foreach (slot_of[t, e]) begin
        slot_of[t][e] = 0;
        owner_of[t][e] = 0;
        payload[t][e] = 0;
      end
    endfunction

    function void write_mask(logic [7:0] m);
      enable_mask = m;
      for (int t = 0; t < esse_pkg::NTYPES; t++)
        if (!m[t]) members[t] = 0;
    endfunction

    function bit lookup(int t, int e, output int unsigned s);
      s = slot_of[t][e];
      return s < members[t] && owner_of[t][s] == e;
    endfunction

    function void drop(int t, int unsigned s);
      int unsigned last, moved;
      last = members[t] - 1;
      moved = owner_of[t][last];
      owner_of[t][s] = moved;
      payload[t][s] = payload[t][last];
      slot_of[t][moved] = s;
      members[t] = last;
    endfunction

    function void note_op(logic [2:0] fn, logic [esse_pkg::ENT_W-1:0] e,
                          logic [esse_pkg::TYPE_W-1:0] t,
                          logic [esse_pkg::DATA_W-1:0] d);
      result_t r;
      int unsigned s;
      r.status = esse_pkg::ST_INVALID;
      r.ent = 0;
      r.data = 0;
      case (fn)
        esse_pkg::F_ENT_ADD: begin
          if (free_cnt > 0) begin
            free_cnt--;
            r.ent = free_ids[free_cnt];
            r.status = esse_pkg::ST_OK;
          end else if (fresh_cnt < 1024) begin
            r.ent = fresh_cnt[esse_pkg::ENT_W-1:0];
            fresh_cnt++;
            r.status = esse_pkg::ST_OK;
          end else r.status = esse_pkg::ST_FULL;
        end
        esse_pkg::F_ENT_REM: begin
          if (e >= fresh_cnt) r.status = esse_pkg::ST_INVALID;
          else if (free_cnt >= 1024) r.status = esse_pkg::ST_FULL;
          else begin
            free_ids[free_cnt] = e;
            free_cnt++;
            for (int k = 0; k < esse_pkg::NTYPES; k++)
              if (enable_mask[k] && lookup(k, e, s)) drop(k, s);
            r.status = esse_pkg::ST_OK;
          end
        end
        esse_pkg::F_COMP_ADD: begin
          if (e >= fresh_cnt) r.status = esse_pkg::ST_INVALID;
          else if (!enable_mask[t]) r.status = esse_pkg::ST_UNREG;
          else if (lookup(t, e, s)) begin
            payload[t][s] = d;
            r.status = esse_pkg::ST_OK;
          end else if (members[t] >= 1024) r.status = esse_pkg::ST_FULL;
          else begin
            s = members[t];
            slot_of[t][e] = s;
            owner_of[t][s] = e;
            payload[t][s] = d;
            members[t] = s + 1;
            r.status = esse_pkg::ST_OK;
          end
        end
        esse_pkg::F_COMP_REM: begin
          if (e >= fresh_cnt) r.status = esse_pkg::ST_INVALID;
          else if (!enable_mask[t]) r.status = esse_pkg::ST_UNREG;
          else if (lookup(t, e, s)) begin
            drop(t, s);
            r.status = esse_pkg::ST_OK;
          end else r.status = esse_pkg::ST_INVALID;
        end
        esse_pkg::F_QUERY: begin
          if (!enable_mask[t]) r.status = esse_pkg::ST_UNREG;
          else if (lookup(t, e, s)) begin
            r.data = payload[t][s];
            r.status = esse_pkg::ST_OK;
          end else r.status = esse_pkg::ST_INVALID;
        end
        default: r.status = esse_pkg::ST_INVALID;
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(logic [47:0] beat);
      result_t x;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result beat %h", $realtime, beat);
        errors++;
        return;
      end
      x = pending.pop_front();
      if (beat[1:0] !== x.status) begin
        $display("%0t: status expected %0d actual %0d", $realtime, x.status, beat[1:0]);
        errors++;
      end
      if (beat[11:2] !== x.ent) begin
        $display("%0t: entity_out expected %0d actual %0d", $realtime, x.ent, beat[11:2]);
        errors++;
      end
      if (beat[43:12] !== x.data) begin
        $display("%0t: data_out expected %h actual %h", $realtime, x.data, beat[43:12]);
        errors++;
      end
      if (beat[47:44] !== 4'd0) begin
        $display("%0t: pad expected 0 actual %h", $realtime, beat[47:44]);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [47:0] s_tdata = 0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [47:0] m_tdata;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = 0;

  entity_store_board board = new();
  bit          rx_hold = 0;
  bit          calm = 0;
  int          quiet = 0;

  always #5 clk = ~clk;

  entity_sparse_set_engine dut (.*);

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_result(m_tdata);
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 20000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold when asked
  initial begin
    int n;
    @(posedge clk);
    while (1) begin
      if (rx_hold) begin
        m_tready <= 0;
        repeat (300) @(posedge clk);
        rx_hold = 0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        m_tready <= 0;
        n = $urandom_range(1, 8);
        repeat (n) @(posedge clk);
      end else begin
        m_tready <= 1;
        @(posedge clk);
      end
    end
  end

  task automatic send_op(logic [2:0] fn, logic [esse_pkg::ENT_W-1:0] e,
                         logic [esse_pkg::TYPE_W-1:0] t, logic [esse_pkg::DATA_W-1:0] d);
    int n;
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 0;
      n = $urandom_range(1, 8);
      repeat (n) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {d, t, e, fn};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_op(fn, e, t, d);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_mask(logic [7:0] m);
    drain();
    cfg_valid <= 1;
    cfg_data <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.write_mask(m);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  function automatic logic [esse_pkg::ENT_W-1:0] pick_entity();
    int unsigned v;
    if (board.fresh_cnt == 0 || $urandom_range(0, 15) == 0) v = $urandom_range(0, 1023);
    else v = $urandom_range(0, board.fresh_cnt - 1);
    return v[esse_pkg::ENT_W-1:0];
  endfunction

  task automatic random_ops(int count);
    int r;
    int unsigned bad_fn;
    int unsigned tv;
    logic [2:0] fn;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 12) fn = esse_pkg::F_ENT_ADD;
      else if (r < 22) fn = esse_pkg::F_ENT_REM;
      else if (r < 55) fn = esse_pkg::F_COMP_ADD;
      else if (r < 70) fn = esse_pkg::F_COMP_REM;
      else if (r < 97) fn = esse_pkg::F_QUERY;
      else begin
        bad_fn = $urandom_range(5, 7);
        fn = bad_fn[2:0];
      end
      tv = $urandom_range(0, 7);
      send_op(fn, pick_entity(), tv[esse_pkg::TYPE_W-1:0], $urandom());
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: empty engine, unregistered types, bad funcs
    send_op(esse_pkg::F_QUERY, 0, 0, 0);
    send_op(esse_pkg::F_ENT_REM, 0, 0, 0);
    send_op(esse_pkg::F_COMP_ADD, 0, 0, 32'hFFFF_FFFF);
    send_op(esse_pkg::F_ENT_ADD, 10'h3FF, 7, 0);
    send_op(esse_pkg::F_COMP_ADD, 0, 7, 32'hFFFF_FFFF);
    send_op(3'd5, 0, 0, 0);
    send_op(3'd7, 10'h3FF, 7, 32'hFFFF_FFFF);
    write_mask(8'hFF);
    send_op(esse_pkg::F_ENT_ADD, 0, 0, 0);
    send_op(esse_pkg::F_ENT_ADD, 0, 0, 0);
    send_op(esse_pkg::F_COMP_ADD, 0, 7, 32'hFFFF_FFFF);
    send_op(esse_pkg::F_COMP_ADD, 1, 7, 32'h0);
    send_op(esse_pkg::F_COMP_ADD, 0, 7, 32'h1234_5678);
    send_op(esse_pkg::F_QUERY, 0, 7, 0);
    send_op(esse_pkg::F_COMP_REM, 0, 7, 0);
    send_op(esse_pkg::F_QUERY, 1, 7, 0);
    send_op(esse_pkg::F_COMP_REM, 0, 7, 0);
    send_op(esse_pkg::F_QUERY, 10'h3FF, 7, 0);
    send_op(esse_pkg::F_COMP_ADD, 10'h3FF, 0, 1);
    send_op(esse_pkg::F_ENT_REM, 1, 0, 0);
    send_op(esse_pkg::F_ENT_REM, 1, 0, 0);
    send_op(esse_pkg::F_ENT_ADD, 0, 0, 0);
    // long receiver hold while input keeps coming
    rx_hold = 1;
    random_ops(40);
    drain();
    write_mask(8'h00);
    random_ops(30);
    write_mask(8'h5A);
    random_ops(60);
    write_mask(8'hA5);
    random_ops(60);
    write_mask(8'hFF);
    // exhaust fresh ids and the free stack
    while (board.fresh_cnt < 1024 || board.free_cnt != 0)
      send_op(esse_pkg::F_ENT_ADD, 0, 0, 0);
    send_op(esse_pkg::F_ENT_ADD, 0, 0, 0);
    random_ops(40);
    send_op(esse_pkg::F_ENT_REM, 5, 0, 0);
    send_op(esse_pkg::F_ENT_ADD, 0, 0, 0);
    write_mask(8'h81);
    random_ops(30);
    calm = 1;
    random_ops(40);
    drain();
    if (board.errors == 0 && board.pending.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
